// File: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int BIT_CNT_W     = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [BIT_CNT_W-1:0]     bit_cnt_t;

    // One shift-and-add step of a modular product:
    // acc <- 2*acc mod m, then acc <- acc + a mod m when the multiplier bit is set.
    // Requires acc < m and a < m.
    function automatic operand_t mulmod_step(
        input operand_t acc,
        input operand_t a,
        input logic     mult_bit,
        input operand_t m
    );
        logic [OPERAND_WIDTH:0] dbl;
        logic [OPERAND_WIDTH:0] sum;
        operand_t               d;
        operand_t               s;
        dbl = {acc, 1'b0};
        if (dbl >= {1'b0, m})
            d = operand_t'(dbl - {1'b0, m});
        else
            d = dbl[OPERAND_WIDTH-1:0];
        sum = {1'b0, d} + {1'b0, a};
        if (sum >= {1'b0, m})
            s = operand_t'(sum - {1'b0, m});
        else
            s = sum[OPERAND_WIDTH-1:0];
        if (mult_bit)
            return s;
        else
            return d;
    endfunction

endpackage

// File: hw/rtl/modular_exponentiation_core.sv
// Modular exponentiation core: power_mod = base ** exponent mod modulus.
//
// Input channel s_*: one transfer carries base (s_tdata[31:0]) and exponent
// (s_tdata[63:32]). Output channel m_*: one transfer per input, power_mod
// in m_tdata[31:0]. Modulus comes from cfg_wr_data, written whenever
// cfg_wr_en is high; write it only while the core is idle.
//
// One shared modular multiplier does one shift-and-add step per cycle, one
// step per multiplier bit. The base is first reduced with that multiplier,
// then each exponent bit, MSB first, costs a square plus a multiply by the
// base when the bit is set. A modulus below two answers 0. s_tready is high
// only while the core is idle, so a new item is taken only after the last
// result has gone to the output register. The result sits in an output
// register; a stalled receiver holds it there, and a finished item waits
// until that register is free.
//
// Reset sets the modulus to 2, empties the output register and idles the core.
`timescale 1ns / 1ps

module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [31:0] base, [63:32] exponent
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] power_mod
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_MULT   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    operand_t   modulus_reg;
    operand_t   base_reg, base_next;
    operand_t   exp_reg, exp_next;
    bit_cnt_t   exp_cnt_reg, exp_cnt_next;
    operand_t   acc_reg, acc_next;
    operand_t   mm_a_reg, mm_a_next;
    operand_t   mm_b_reg, mm_b_next;
    operand_t   mm_acc_reg, mm_acc_next;
    bit_cnt_t   mm_cnt_reg, mm_cnt_next;
    logic       out_valid_reg, out_valid_next;
    operand_t   out_data_reg, out_data_next;

    operand_t   mm_step;
    logic       mm_last;
    logic       in_xfer;
    logic       out_xfer;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign mm_step = mulmod_step(mm_acc_reg, mm_a_reg, mm_b_reg[OPERAND_WIDTH-1], modulus_reg);
    assign mm_last = (mm_cnt_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        exp_cnt_next   = exp_cnt_reg;
        acc_next       = acc_reg;
        mm_a_next      = mm_a_reg;
        mm_b_next      = mm_b_reg;
        mm_acc_next    = mm_acc_reg;
        mm_cnt_next    = mm_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_xfer)
            out_valid_next = 1'b0;

        // advance the shared multiplier one bit
        if (state_reg == ST_REDUCE || state_reg == ST_SQUARE || state_reg == ST_MULT)
        begin
            mm_acc_next = mm_step;
            mm_b_next   = {mm_b_reg[OPERAND_WIDTH-2:0], 1'b0};
            mm_cnt_next = mm_cnt_reg - bit_cnt_t'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    exp_next     = s_tdata[63:32];
                    exp_cnt_next = bit_cnt_t'(OPERAND_WIDTH - 1);
                    if (modulus_reg < operand_t'(2))
                    begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // base mod m as the product 1 * base
                        mm_a_next   = operand_t'(1);
                        mm_b_next   = s_tdata[31:0];
                        mm_acc_next = '0;
                        mm_cnt_next = bit_cnt_t'(OPERAND_WIDTH - 1);
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_last)
                begin
                    base_next   = mm_step;
                    acc_next    = operand_t'(1);
                    mm_a_next   = operand_t'(1);
                    mm_b_next   = operand_t'(1);
                    mm_acc_next = '0;
                    mm_cnt_next = bit_cnt_t'(OPERAND_WIDTH - 1);
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mm_last)
                begin
                    acc_next    = mm_step;
                    mm_acc_next = '0;
                    mm_cnt_next = bit_cnt_t'(OPERAND_WIDTH - 1);
                    if (exp_reg[OPERAND_WIDTH-1])
                    begin
                        mm_a_next  = base_reg;
                        mm_b_next  = mm_step;
                        state_next = ST_MULT;
                    end
                    else if (exp_cnt_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        exp_next     = {exp_reg[OPERAND_WIDTH-2:0], 1'b0};
                        exp_cnt_next = exp_cnt_reg - bit_cnt_t'(1);
                        mm_a_next    = mm_step;
                        mm_b_next    = mm_step;
                        state_next   = ST_SQUARE;
                    end
                end
            end
            ST_MULT:
            begin
                if (mm_last)
                begin
                    acc_next    = mm_step;
                    mm_acc_next = '0;
                    mm_cnt_next = bit_cnt_t'(OPERAND_WIDTH - 1);
                    if (exp_cnt_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        exp_next     = {exp_reg[OPERAND_WIDTH-2:0], 1'b0};
                        exp_cnt_next = exp_cnt_reg - bit_cnt_t'(1);
                        mm_a_next    = mm_step;
                        mm_b_next    = mm_step;
                        state_next   = ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= operand_t'(2);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                modulus_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        exp_cnt_reg  <= exp_cnt_next;
        acc_reg      <= acc_next;
        mm_a_reg     <= mm_a_next;
        mm_b_reg     <= mm_b_next;
        mm_acc_reg   <= mm_acc_next;
        mm_cnt_reg   <= mm_cnt_next;
        out_data_reg <= out_data_next;
    end

    // the multiplier partial result stays reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE || state_reg == ST_MULT) |-> mm_acc_reg < modulus_reg)
        else $error("multiplier accumulator not reduced");

    // operands of a multiply by the base are reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULT) |-> (mm_a_reg < modulus_reg && base_reg < modulus_reg))
        else $error("multiply operand not reduced");

    // an accepted item starts work the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg != ST_IDLE)
        else $error("accepted item dropped");

    // a delivered result is below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && modulus_reg >= operand_t'(2)) |-> out_data_reg < modulus_reg)
        else $error("result not reduced");

endmodule
